// ===== hdl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// Used by every module of the block; depends on nothing.
package rgbhsv_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int COMP_FULL      = (1 << COMPONENT_BITS) - 1;
    // 2^16 = COMP_FULL * BRIGHT_MULT + 2^BRIGHT_SHIFT
    localparam int BRIGHT_SHIFT   = 16 % COMPONENT_BITS;
    localparam int BRIGHT_MULT    = (65536 - (1 << BRIGHT_SHIFT)) / COMP_FULL;
    // 60 degrees in radians, Q3.13
    localparam int HUE_SIXTH      = 8579;
    localparam int SECTOR_W       = COMPONENT_BITS + 3;
    localparam int DIV_QW         = 17;
    localparam int DIV_W          = COMPONENT_BITS + DIV_QW;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } rgb_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] brightness;
    } hsv_t;

    typedef struct packed {
        comp_t               hi;
        comp_t               delta;
        logic [SECTOR_W-1:0] n;
        logic [16:0]         bright;
        logic                grey;
    } front_item_t;

endpackage

// ===== hdl/rgb_to_hsv.sv =====
// Top level of the RGB to HSV converter.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_fifo and rgbhsv_back.
//
// Usage:
//   rgb channel (rgb_valid / rgb_ready / rgb) carries one pixel per item:
//   unsigned red, green and blue components.
//   hsv channel (hsv_valid / hsv_ready / hsv) returns one item per pixel:
//   hue in radians (Q3.13), saturation and value (Q1.16, 65536 is 1.0).
//   A grey pixel gives hue 0 and saturation 0.
// Timing:
//   Throughput is one pixel per clock when nothing stalls. A pixel passes
//   the front register, the queue, then in the back end its input register
//   and the two 17-stage restoring dividers (one quotient bit per stage).
//   The front end registers max, delta, hue numerator and value, then
//   a two-entry queue decouples it from the back end.
// Reset:
//   rst_n clears all valid flags and the queue; items in flight are dropped, none is made up.
// Stall:
//   While hsv_ready is low with a result waiting, the back end holds; the
//   queue and front register keep taking pixels until they fill, then
//   rgb_ready drops.
module rgb_to_hsv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rgb_valid,
    output logic               rgb_ready,
    input  rgbhsv_pkg::rgb_t   rgb,
    output logic               hsv_valid,
    input  logic               hsv_ready,
    output rgbhsv_pkg::hsv_t   hsv
);
    import rgbhsv_pkg::*;

    // front end to queue
    logic        fq_valid;
    logic        fq_ready;
    front_item_t fq_item;
    // queue to back end
    logic        qb_valid;
    logic        qb_ready;
    front_item_t qb_item;

    rgbhsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .rgb        (rgb),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    rgbhsv_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_item)
    );

    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hsv        (hsv)
    );

`ifndef SYNTH
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.saturation <= 17'd65536) && (hsv.brightness <= 17'd65536)
                      && (hsv.hue <= 16'd51473))
        else $error("hsv result out of range");

    a_grey : assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv.saturation == 17'd0) |-> (hsv.hue == 16'd0))
        else $error("grey pixel with non-zero hue");

    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv.brightness == 17'd0) |-> (hsv.saturation == 17'd0))
        else $error("black pixel with non-zero saturation");
`endif

endmodule

// ===== hdl/rgbhsv_front.sv =====
// Front end: takes a pixel, finds max, min, delta, hue numerator and value.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rgb_valid,
    output logic                     rgb_ready,
    input  rgbhsv_pkg::rgb_t         rgb,
    output logic                     item_valid,
    input  logic                     item_ready,
    output rgbhsv_pkg::front_item_t  item
);
    import rgbhsv_pkg::*;

    localparam int CB = COMPONENT_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    front_item_t          item_reg;
    front_item_t          item_next;

    comp_t                hi;
    comp_t                lo;
    comp_t                delta;
    logic signed [CB+3:0] r_s;
    logic signed [CB+3:0] g_s;
    logic signed [CB+3:0] b_s;
    logic signed [CB+3:0] d_s;
    logic signed [CB+3:0] n_s;
    logic [2*CB-1:0]      bx;
    logic [CB:0]          bsum;
    logic [1:0]           bfix;

    always_comb
    begin
        hi = rgb.red;
        lo = rgb.red;
        if (rgb.green > hi)
        begin
            hi = rgb.green;
        end
        if (rgb.blue > hi)
        begin
            hi = rgb.blue;
        end
        if (rgb.green < lo)
        begin
            lo = rgb.green;
        end
        if (rgb.blue < lo)
        begin
            lo = rgb.blue;
        end
        delta = hi - lo;

        r_s = $signed({4'b0, rgb.red});
        g_s = $signed({4'b0, rgb.green});
        b_s = $signed({4'b0, rgb.blue});
        d_s = $signed({4'b0, delta});
        if (rgb.red == hi)
        begin
            n_s = g_s - b_s;
        end
        else if (rgb.green == hi)
        begin
            n_s = (d_s <<< 1) + b_s - r_s;
        end
        else
        begin
            n_s = (d_s <<< 2) + r_s - g_s;
        end
        if (n_s < 0)
        begin
            n_s = n_s + (d_s <<< 2) + (d_s <<< 1);
        end

        // value = hi * 2^16 / COMP_FULL, split into a product and a small fold
        bx   = (2*CB)'(hi) << BRIGHT_SHIFT;
        bsum = {1'b0, bx[2*CB-1:CB]} + {1'b0, bx[CB-1:0]};
        if (bsum >= (CB+1)'(2 * COMP_FULL))
        begin
            bfix = 2'd2;
        end
        else if (bsum >= (CB+1)'(COMP_FULL))
        begin
            bfix = 2'd1;
        end
        else
        begin
            bfix = 2'd0;
        end

        item_next.hi     = hi;
        item_next.delta  = delta;
        item_next.n      = n_s[SECTOR_W-1:0];
        item_next.bright = 17'(hi) * 17'(BRIGHT_MULT) + 17'(bx[2*CB-1:CB]) + 17'(bfix);
        item_next.grey   = (delta == '0);
    end

    assign rgb_ready  = !valid_reg || item_ready;
    assign valid_next = rgb_ready ? rgb_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rgb_valid && rgb_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/rgbhsv_fifo.sv =====
// Two-entry queue between front and back ends.
// Depends on rgbhsv_pkg.
module rgbhsv_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  rgbhsv_pkg::front_item_t  push_data,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output rgbhsv_pkg::front_item_t  pop_data
);
    import rgbhsv_pkg::*;

    front_item_t mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/rgbhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rgbhsv_pkg; quotient must fit in DIV_QW bits.
module rgbhsv_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic [rgbhsv_pkg::DIV_W-1:0]       dividend,
    input  rgbhsv_pkg::comp_t                  divisor,
    output logic [rgbhsv_pkg::DIV_QW-1:0]      quotient
);
    import rgbhsv_pkg::*;

    localparam int CB = COMPONENT_BITS;

    comp_t             rem_reg  [DIV_QW];
    comp_t             rem_next [DIV_QW];
    comp_t             den_reg  [DIV_QW];
    logic [DIV_QW-1:0] low_reg  [DIV_QW];
    logic [DIV_QW-1:0] q_reg    [DIV_QW];
    logic [DIV_QW-1:0] q_next   [DIV_QW];

    for (genvar s = 0; s < DIV_QW; s++)
    begin : g_stage
        localparam int BIT = DIV_QW - 1 - s;

        comp_t             rem_in;
        comp_t             den_in;
        logic [DIV_QW-1:0] low_in;
        logic [DIV_QW-1:0] q_in;
        logic [CB:0]       trial;
        logic [CB:0]       diff;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign rem_in = dividend[DIV_W-1:DIV_QW];
            assign den_in = divisor;
            assign low_in = dividend[DIV_QW-1:0];
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign low_in = low_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_in, low_in[BIT]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            rem_next[s] = ge ? diff[CB-1:0] : trial[CB-1:0];
            q_next[s]      = q_in;
            q_next[s][BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_in;
                low_reg[s] <= low_in;
                q_reg[s]   <= q_next[s];
            end
        end
    end

    assign quotient = q_reg[DIV_QW-1];

endmodule

// ===== hdl/rgbhsv_back.sv =====
// Back end: forms the divisions for saturation and hue and holds the result.
// Depends on rgbhsv_pkg and rgbhsv_div.
module rgbhsv_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  rgbhsv_pkg::front_item_t  item,
    output logic                     hsv_valid,
    input  logic                     hsv_ready,
    output rgbhsv_pkg::hsv_t         hsv
);
    import rgbhsv_pkg::*;

    logic              en;
    logic              s0_valid_reg;
    logic [DIV_W-1:0]  hue_num_reg;
    logic [DIV_W-1:0]  sat_num_reg;
    comp_t             delta_reg;
    comp_t             hi_reg;
    logic [16:0]       bright0_reg;
    logic              grey0_reg;

    logic              vld_reg    [DIV_QW];
    logic [16:0]       bright_reg [DIV_QW];
    logic              grey_reg   [DIV_QW];

    logic [DIV_QW-1:0] hue_q;
    logic [DIV_QW-1:0] sat_q;

    // whole pipeline advances together; the last stage is the output register
    assign en         = !vld_reg[DIV_QW-1] || hsv_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_QW; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_valid_reg <= item_valid;
            vld_reg[0]   <= s0_valid_reg;
            for (int i = 1; i < DIV_QW; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_num_reg   <= DIV_W'(item.n) * DIV_W'(HUE_SIXTH);
            sat_num_reg   <= DIV_W'({item.delta, 16'b0});
            delta_reg     <= item.delta;
            hi_reg        <= item.hi;
            bright0_reg   <= item.bright;
            grey0_reg     <= item.grey;
            bright_reg[0] <= bright0_reg;
            grey_reg[0]   <= grey0_reg;
            for (int i = 1; i < DIV_QW; i++)
            begin
                bright_reg[i] <= bright_reg[i-1];
                grey_reg[i]   <= grey_reg[i-1];
            end
        end
    end

    rgbhsv_div u_hue_div (
        .clk      (clk),
        .en       (en),
        .dividend (hue_num_reg),
        .divisor  (delta_reg),
        .quotient (hue_q)
    );

    rgbhsv_div u_sat_div (
        .clk      (clk),
        .en       (en),
        .dividend (sat_num_reg),
        .divisor  (hi_reg),
        .quotient (sat_q)
    );

    assign hsv_valid      = vld_reg[DIV_QW-1];
    assign hsv.hue        = grey_reg[DIV_QW-1] ? 16'd0 : hue_q[15:0];
    assign hsv.saturation = grey_reg[DIV_QW-1] ? 17'd0 : sat_q;
    assign hsv.brightness = bright_reg[DIV_QW-1];

endmodule

// ===== bench/rgbhsv_checker.sv =====
// Checker for the RGB to HSV converter: watches both channels, predicts
// each pixel's hue, saturation and value and compares in order.
// Depends on rgbhsv_pkg.
module rgbhsv_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rgb_valid,
    input  logic             rgb_ready,
    input  rgbhsv_pkg::rgb_t rgb,
    input  logic             hsv_valid,
    input  logic             hsv_ready,
    input  rgbhsv_pkg::hsv_t hsv,
    output int               fail_count,
    output int               pending
);
    import rgbhsv_pkg::*;

    hsv_t hsv_expected_q[$];

    function automatic hsv_t convert_pixel(rgb_t px);
        int r;
        int g;
        int b;
        int hi;
        int lo;
        int delta;
        int n;
        hsv_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        res.brightness = 17'((hi * 65536) / COMP_FULL);
        res.hue = '0;
        res.saturation = '0;
        if (delta != 0)
        begin
            res.saturation = 17'((delta * 65536) / hi);
            // ties go to red, then green
            if (r == hi)
                n = g - b;
            else if (g == hi)
                n = 2 * delta + (b - r);
            else
                n = 4 * delta + (r - g);
            if (n < 0)
                n += 6 * delta;
            res.hue = 16'((n * HUE_SIXTH) / delta);
        end
        return res;
    endfunction

    assign pending = hsv_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (rgb_valid && rgb_ready)
                hsv_expected_q.push_back(convert_pixel(rgb));
            if (hsv_valid && hsv_ready)
            begin
                if (hsv_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, hsv);
                    fail_count <= fail_count + 1;
                end
                else if (hsv_expected_q[0] !== hsv)
                begin
                    $display("%0t: expected hue %0d sat %0d val %0d, got %0d %0d %0d",
                             $time, hsv_expected_q[0].hue, hsv_expected_q[0].saturation,
                             hsv_expected_q[0].brightness, hsv.hue, hsv.saturation,
                             hsv.brightness);
                    fail_count <= fail_count + 1;
                    void'(hsv_expected_q.pop_front());
                end
                else
                    void'(hsv_expected_q.pop_front());
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the RGB to HSV converter bench: clock, reset, pixel stimulus,
// result stalls and verdict. Depends on rgbhsv_pkg, rgb_to_hsv, rgbhsv_checker.
module testbench;
    import rgbhsv_pkg::*;

    logic clk;
    logic rst_n;
    logic rgb_valid;
    logic rgb_ready;
    rgb_t rgb;
    logic hsv_valid;
    logic hsv_ready;
    hsv_t hsv;
    int   fail_count;
    int   pending;

    rgb_to_hsv u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    rgbhsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .rgb        (rgb),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hsv        (hsv),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stall pattern: calm stretches, then spells of random stalls.
    initial
    begin
        int mode;
        hsv_ready = 1'b0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: hsv_ready <= 1'b1;
                1: hsv_ready <= ($urandom_range(0, 3) != 0);
                default: hsv_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Present one pixel and hold it until accepted.
    task automatic send_pixel(input rgb_t px);
        rgb_valid <= 1'b1;
        rgb       <= px;
        @(posedge clk);
        while (!rgb_ready)
            @(posedge clk);
    endtask

    // Drop valid and let a number of cycles pass.
    task automatic idle_cycles(input int n);
        rgb_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic rgb_t random_pixel();
        rgb_t px;
        int kind;
        px = rgb_t'($urandom);
        kind = $urandom_range(0, 7);
        // bias some pixels towards ties and greys
        if (kind == 0)
            px.green = px.red;
        else if (kind == 1)
            px.blue = px.green;
        else if (kind == 2)
        begin
            px.green = px.red;
            px.blue = px.red;
        end
        else if (kind == 3)
            px.blue = px.red;
        return px;
    endfunction

    initial
    begin
        rgb_t directed[$];
        int   burst;
        int   sent;
        rst_n     = 1'b0;
        rgb_valid = 1'b0;
        rgb       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Black, white, greys, primaries, ties and each hue sector.
        directed = '{
            '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
            '{8'd1, 8'd1, 8'd1}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
            '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
            '{8'd255, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd1}, '{8'd1, 8'd0, 8'd0},
            '{8'd0, 8'd1, 8'd0}, '{8'd0, 8'd0, 8'd1}, '{8'd200, 8'd100, 8'd50},
            '{8'd50, 8'd200, 8'd100}, '{8'd100, 8'd50, 8'd200}, '{8'd255, 8'd254, 8'd254},
            '{8'd170, 8'd85, 8'd85}, '{8'd85, 8'd170, 8'd170}
        };
        foreach (directed[i])
            send_pixel(directed[i]);

        // Hold off until every result of the directed part has arrived.
        rgb_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        sent = 0;
        while (sent < 800)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send_pixel(random_pixel());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        rgb_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
